[hw/rtl/rss_pkg.sv]
// rss_pkg: shared types, request codes and the byte compare for the
// record substring search core. No dependencies.

package rss_pkg;

    localparam int PAT_CELLS   = 64;   // pattern bytes held, one per cell
    localparam int MAX_RECORDS = 256;  // records reported per clear

    // index of the last record that still gets a result beat
    localparam logic [7:0] REC_LAST = 8'(MAX_RECORDS - 1);

    localparam logic [2:0] REQ_CLEAR      = 3'd0;
    localparam logic [2:0] REQ_APPEND     = 3'd1;
    localparam logic [2:0] REQ_FIELD_BYTE = 3'd2;
    localparam logic [2:0] REQ_END_FIELD  = 3'd3;
    localparam logic [2:0] REQ_END_RECORD = 3'd4;

    localparam logic [1:0] FIELD_NAME   = 2'd0;
    localparam logic [1:0] FIELD_NUMBER = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  data_byte;
        logic [30:0] reg_number;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] record_index;
        logic       hit;
        logic [1:0] hit_field;
        logic [8:0] hit_count;
    } rsp_beat_t;

    // broadcast to every cell
    typedef struct packed {
        logic clear;   // drop the pattern
        logic append;  // load data byte into the first empty cell
        logic shift;   // advance partial matches by one field byte
        logic flush;   // zero partial matches
    } cell_ctrl_t;

    // letters compare without case, everything else exactly
    function automatic logic byte_match(input logic [7:0] p, input logic [7:0] c);
        logic is_letter;
        begin
            is_letter = ((p >= CH_LO_A) && (p <= CH_LO_Z)) ||
                        ((p >= CH_UP_A) && (p <= CH_UP_Z));
            if (is_letter)
                byte_match = ((c | CASE_BIT) == (p | CASE_BIT));
            else
                byte_match = (c == p);
        end
    endfunction

endpackage

[hw/rtl/rss_cell.sv]
// rss_cell: one pattern byte and its partial-match bit.
// Depends on rss_pkg.

module rss_cell
    import rss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] data_byte,
    input  logic       prev_active,
    input  logic       prev_pm,
    input  logic       next_active,
    output logic       active,
    output logic       pm,
    output logic       hit
);

    logic       active_reg, active_next;
    logic       pm_reg, pm_next;
    logic [7:0] pat_reg;
    logic       load;
    logic       step;

    assign load = ctrl.append && !active_reg && prev_active;
    assign step = prev_pm && active_reg && byte_match(pat_reg, data_byte);

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.clear)
            active_next = 1'b0;
        else if (load)
            active_next = 1'b1;

        pm_next = pm_reg;
        if (ctrl.flush)
            pm_next = 1'b0;
        else if (ctrl.shift)
            pm_next = step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pm_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pm_reg     <= pm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pat_reg <= data_byte;
    end

    assign active = active_reg;
    assign pm     = pm_reg;
    // full pattern ends here when this is the last loaded cell
    assign hit    = ctrl.shift && step && !next_active;

endmodule

[hw/rtl/rss_obuf.sv]
// rss_obuf: output register plus one skid entry for result beats.
// Depends on rss_pkg.

module rss_obuf
    import rss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  rsp_beat_t res,
    output logic      full,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    rsp_beat_t out_reg, out_next;
    rsp_beat_t skid_reg, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[hw/rtl/record_substring_search_core.sv]
// record_substring_search_core: case-insensitive pattern search over records.
// A result beat reaches rsp via the output register (skid entry first on a stall).
// Throughput: one request beat per cycle, every beat type; req_stall rises only
//   while the skid entry of the output buffer is occupied.
// Reset (rst_n, async, active low) empties the pattern, counters and buffers.
// Depends on rss_pkg, rss_cell, rss_obuf.

module record_substring_search_core
    import rss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    logic accept;
    logic do_clear, do_append, do_field, do_end_field, do_end_record;

    logic [PAT_CELLS-1:0] act_vec, pm_vec, hit_vec;
    cell_ctrl_t           ctrl;
    logic                 pat_empty, pat_full, any_hit;

    // record and pattern bookkeeping
    logic [1:0]  field_number_reg, field_number_next;
    logic        record_matched_reg, record_matched_next;
    logic [1:0]  matched_field_reg, matched_field_next;
    logic [7:0]  record_counter_reg, record_counter_next;
    logic [8:0]  match_counter_reg, match_counter_next;
    logic        records_full_reg, records_full_next;
    logic [30:0] pattern_value_reg, pattern_value_next;
    logic        pattern_numeric_reg, pattern_numeric_next;

    logic        is_digit;
    logic [34:0] value_x10;
    logic        res_valid;
    rsp_beat_t   res;
    logic        rec_hit;
    logic [1:0]  rec_field;
    logic [8:0]  count_inc;

    assign accept = req_valid && !req_stall;

    // request decode
    always_comb
    begin
        do_clear      = 1'b0;
        do_append     = 1'b0;
        do_field      = 1'b0;
        do_end_field  = 1'b0;
        do_end_record = 1'b0;
        unique case (req.req_type)
            REQ_CLEAR:      do_clear      = accept;
            REQ_APPEND:     do_append     = accept;
            REQ_FIELD_BYTE: do_field      = accept;
            REQ_END_FIELD:  do_end_field  = accept;
            REQ_END_RECORD: do_end_record = accept;
            default:        ;  // unused codes are dropped
        endcase
    end

    assign pat_empty = !act_vec[0];
    assign pat_full  = act_vec[PAT_CELLS-1];

    // field bytes past the third field, or with no pattern, leave the cells alone
    assign ctrl.clear  = do_clear;
    assign ctrl.append = do_append;
    assign ctrl.shift  = do_field && (field_number_reg != FIELD_NUMBER) && !pat_empty;
    assign ctrl.flush  = do_clear || do_end_field || do_end_record;

    // cell chain: cell 0 always sees an open match start and a loaded left side
    genvar gi;
    generate
        for (gi = 0; gi < PAT_CELLS; gi++)
        begin : g_cell
            logic prev_act, prev_pm, next_act;
            if (gi == 0)
            begin : g_head
                assign prev_act = 1'b1;
                assign prev_pm  = 1'b1;
            end
            else
            begin : g_body
                assign prev_act = act_vec[gi-1];
                assign prev_pm  = pm_vec[gi-1];
            end
            if (gi == PAT_CELLS - 1)
            begin : g_tail
                assign next_act = 1'b0;
            end
            else
            begin : g_inner
                assign next_act = act_vec[gi+1];
            end

            rss_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .data_byte   (req.data_byte),
                .prev_active (prev_act),
                .prev_pm     (prev_pm),
                .next_active (next_act),
                .active      (act_vec[gi]),
                .pm          (pm_vec[gi]),
                .hit         (hit_vec[gi])
            );
        end
    endgenerate

    assign any_hit = |hit_vec;

    // decimal value of the pattern, tracked as bytes are appended
    assign is_digit  = (req.data_byte >= CH_ZERO) && (req.data_byte <= CH_NINE);
    assign value_x10 = {1'b0, pattern_value_reg, 3'b000}
                     + {3'b000, pattern_value_reg, 1'b0}
                     + {31'd0, 4'(req.data_byte - CH_ZERO)};

    // per-record verdict: empty pattern hits on the name, then a field match,
    // then the registration number
    always_comb
    begin
        rec_hit   = 1'b1;
        rec_field = FIELD_NAME;
        if (pat_empty)
            rec_field = FIELD_NAME;
        else if (record_matched_reg)
            rec_field = matched_field_reg;
        else if (pattern_numeric_reg && (req.reg_number == pattern_value_reg))
            rec_field = FIELD_NUMBER;
        else
        begin
            rec_hit   = 1'b0;
            rec_field = FIELD_NAME;
        end
    end

    assign count_inc = (rec_hit && (match_counter_reg != 9'h1ff))
                     ? match_counter_reg + 9'd1 : match_counter_reg;

    assign res_valid        = do_end_record && !records_full_reg;
    assign res.record_index = record_counter_reg;
    assign res.hit          = rec_hit;
    assign res.hit_field    = rec_field;
    assign res.hit_count    = count_inc;

    always_comb
    begin
        field_number_next    = field_number_reg;
        record_matched_next  = record_matched_reg;
        matched_field_next   = matched_field_reg;
        record_counter_next  = record_counter_reg;
        match_counter_next   = match_counter_reg;
        records_full_next    = records_full_reg;
        pattern_value_next   = pattern_value_reg;
        pattern_numeric_next = pattern_numeric_reg;

        if (do_clear)
        begin
            field_number_next    = FIELD_NAME;
            record_matched_next  = 1'b0;
            matched_field_next   = FIELD_NAME;
            record_counter_next  = 8'd0;
            match_counter_next   = 9'd0;
            records_full_next    = 1'b0;
            pattern_value_next   = 31'd0;
            pattern_numeric_next = 1'b1;
        end

        if (do_append && !pat_full && pattern_numeric_reg)
        begin
            if (is_digit && (value_x10[34:31] == 4'd0))
                pattern_value_next = value_x10[30:0];
            else
            begin
                pattern_numeric_next = 1'b0;
                pattern_value_next   = 31'd0;
            end
        end

        if (any_hit && !record_matched_reg)
        begin
            record_matched_next = 1'b1;
            matched_field_next  = field_number_reg;
        end

        if (do_end_field && (field_number_reg != FIELD_NUMBER))
            field_number_next = field_number_reg + 2'd1;

        if (do_end_record)
        begin
            if (!records_full_reg)
            begin
                match_counter_next = count_inc;
                if (record_counter_reg == REC_LAST)
                    records_full_next = 1'b1;
                else
                    record_counter_next = record_counter_reg + 8'd1;
            end
            field_number_next   = FIELD_NAME;
            record_matched_next = 1'b0;
            matched_field_next  = FIELD_NAME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg    <= FIELD_NAME;
            record_matched_reg  <= 1'b0;
            matched_field_reg   <= FIELD_NAME;
            record_counter_reg  <= 8'd0;
            match_counter_reg   <= 9'd0;
            records_full_reg    <= 1'b0;
            pattern_value_reg   <= 31'd0;
            pattern_numeric_reg <= 1'b1;
        end
        else
        begin
            field_number_reg    <= field_number_next;
            record_matched_reg  <= record_matched_next;
            matched_field_reg   <= matched_field_next;
            record_counter_reg  <= record_counter_next;
            match_counter_reg   <= match_counter_next;
            records_full_reg    <= records_full_next;
            pattern_value_reg   <= pattern_value_next;
            pattern_numeric_reg <= pattern_numeric_next;
        end
    end

    // result beat leaves through a register; the skid entry absorbs one more
    rss_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
